// File: rtl/core/assert_macros.svh
// assertion macros shared by the gray code net generator rtl
// depends on nothing; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent holds in this cycle, consequent in the next one
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/gcdn_pkg.sv
// shared types, codes and helpers of the gray code digital net generator
// depends on nothing
`default_nettype none

package gcdn_pkg;

  // default sizes
  localparam int GCDN_MAX_COLUMNS = 32;
  localparam int GCDN_PRECISION   = 64;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int COL_W    = 5;
  localparam int VALUE_W  = 64;
  localparam int INDEX_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;
  localparam int TZ_W     = 6;
  localparam int LIMIT_W  = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_NEXT
  } gcdn_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_load;
    logic accept_start;
    logic accept_next;
    logic scan_step;
    logic finish_start;
    logic finish_next;
  } gcdn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } gcdn_sts_t;

  // count of trailing zeros, 32 for a zero word
  function automatic logic [TZ_W-1:0] ctz32(input logic [INDEX_W-1:0] v);
    logic [INDEX_W-1:0] iso;
    logic [TZ_W-1:0]    n;
    iso = v & (~v + 32'd1);
    n   = '0;
    for (int i = 0; i < INDEX_W; i++) begin
      if (iso[i]) begin
        n = n | TZ_W'(i);
      end
    end
    if (v == '0) begin
      n = TZ_W'(INDEX_W);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcdn_ram.sv
// generic ram, one write port and one registered read port
// depends on nothing
`default_nettype none

module gcdn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/gcdn_ctrl.sv
// controller state machine of the gray code digital net generator
// depends on gcdn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module gcdn_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [gcdn_pkg::OP_W-1:0] in_operation,
  output logic                           in_stall,
  input  wire gcdn_pkg::gcdn_sts_t       sts,
  output gcdn_pkg::gcdn_cmd_t            cmd
);
  import gcdn_pkg::*;

  gcdn_state_t state_r, state_nxt;
  logic        accept;

  // input transfer only while idle
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_START) begin
          state_nxt = ST_SCAN;
        end else if (accept && in_operation == OP_NEXT) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NEXT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept_load  = accept && (in_operation == OP_LOAD);
        cmd.accept_start = accept && (in_operation == OP_START);
        cmd.accept_next  = accept && (in_operation == OP_NEXT);
      end
      ST_SCAN:  cmd.scan_step    = 1'b1;
      ST_DRAIN: cmd.finish_start = sts.out_free;
      ST_NEXT:  cmd.finish_next  = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  // checks
  `ASSERT_NEXT(a_start_enters_scan, clk, rst_n, cmd.accept_start, state_r == ST_SCAN)
  `ASSERT_NEXT(a_scan_runs_on, clk, rst_n, state_r == ST_SCAN && !sts.scan_last,
               state_r == ST_SCAN)
  `ASSERT_NEXT(a_drain_waits, clk, rst_n, state_r == ST_DRAIN && !sts.out_free,
               state_r == ST_DRAIN)

endmodule

`default_nettype wire

// File: rtl/core/gcdn_dp.sv
// datapath: column store, gray scan accumulator, point state, result register
// depends on gcdn_pkg, gcdn_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module gcdn_dp #(
  parameter int MAX_COLUMNS = gcdn_pkg::GCDN_MAX_COLUMNS,
  parameter int PRECISION   = gcdn_pkg::GCDN_PRECISION
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gcdn_pkg::gcdn_cmd_t           cmd,
  output gcdn_pkg::gcdn_sts_t                sts,
  input  wire logic [gcdn_pkg::COL_W-1:0]    in_column_index,
  input  wire logic [gcdn_pkg::VALUE_W-1:0]  in_column_value,
  input  wire logic [gcdn_pkg::INDEX_W-1:0]  in_start_index,
  input  wire logic                          cfg_valid,
  input  wire logic [gcdn_pkg::CFG_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gcdn_pkg::VALUE_W-1:0]       out_point_bits,
  output logic [gcdn_pkg::INDEX_W-1:0]       out_point_index,
  output logic [gcdn_pkg::STATUS_W-1:0]      out_status
);
  import gcdn_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [COL_W-1:0]   LAST_BIT = '1;
  localparam logic [LIMIT_W-1:0] MAX_COLS = LIMIT_W'(MAX_COLUMNS);

  logic [CFG_W-1:0]     cfg_r;
  logic [INDEX_W-1:0]   gray_r;
  logic [INDEX_W-1:0]   sidx_r;
  logic [COL_W-1:0]     bit_r;
  logic [PRECISION-1:0] acc_r;
  logic                 pend_r;
  logic                 err_r;
  logic [PRECISION-1:0] cur_point_r;
  logic [INDEX_W-1:0]   cur_index_r;
  logic                 started_r;
  logic                 out_valid_r;
  logic [PRECISION-1:0] point_r;
  logic [INDEX_W-1:0]   index_r;
  logic [STATUS_W-1:0]  status_r;

  logic [LIMIT_W-1:0]   limit;
  logic                 gray_bit;
  logic                 bit_in_store;
  logic                 bit_beyond;
  logic [INDEX_W-1:0]   nidx;
  logic [TZ_W-1:0]      tz;
  logic                 tz_beyond;
  logic [PRECISION-1:0] fin_acc;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [PRECISION-1:0] rd_data;

  // column limit is the smaller of the register and the store depth
  assign limit = (LIMIT_W'(cfg_r) < MAX_COLS) ? LIMIT_W'(cfg_r) : MAX_COLS;

  // scan step decode
  assign gray_bit     = gray_r[bit_r];
  assign bit_in_store = LIMIT_W'(bit_r) < MAX_COLS;
  assign bit_beyond   = LIMIT_W'(bit_r) >= limit;

  // next index and its column
  assign nidx      = cur_index_r + 32'd1;
  assign tz        = ctz32(nidx);
  assign tz_beyond = LIMIT_W'(tz) >= limit;

  assign fin_acc = acc_r ^ (pend_r ? rd_data : '0);

  // column store access
  assign wr_en   = cmd.accept_load && (LIMIT_W'(in_column_index) < MAX_COLS);
  assign wr_addr = AW'(in_column_index);
  assign rd_en   = cmd.scan_step ? (gray_bit && bit_in_store)
                 : (cmd.accept_next && (nidx != '0) && (LIMIT_W'(tz) < MAX_COLS));
  assign rd_addr = cmd.scan_step ? AW'(bit_r) : AW'(tz);

  gcdn_ram #(
    .WIDTH (PRECISION),
    .DEPTH (MAX_COLUMNS)
  ) u_cols (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_column_value[PRECISION-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  // gray scan of a start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      pend_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (cmd.accept_start) begin
      bit_r  <= '0;
      pend_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      bit_r  <= bit_r + 5'd1;
      pend_r <= gray_bit && bit_in_store;
      err_r  <= err_r || (gray_bit && bit_beyond);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_start) begin
      gray_r <= in_start_index ^ (in_start_index >> 1);
      sidx_r <= in_start_index;
      acc_r  <= '0;
    end else if (cmd.scan_step) begin
      acc_r  <= fin_acc;
    end
  end

  // point state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_point_r <= '0;
      cur_index_r <= '0;
      started_r   <= 1'b0;
    end else if (cmd.finish_start) begin
      if (err_r) begin
        started_r   <= 1'b0;
      end else begin
        cur_point_r <= fin_acc;
        cur_index_r <= sidx_r;
        started_r   <= 1'b1;
      end
    end else if (cmd.finish_next && started_r && (nidx != '0) && !tz_beyond) begin
      cur_point_r <= cur_point_r ^ rd_data;
      cur_index_r <= nidx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish_start || cmd.finish_next) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_start) begin
      index_r <= sidx_r;
      if (err_r) begin
        point_r  <= '0;
        status_r <= STATUS_RANGE;
      end else begin
        point_r  <= fin_acc;
        status_r <= STATUS_OK;
      end
    end else if (cmd.finish_next) begin
      priority if (!started_r) begin
        point_r  <= '0;
        index_r  <= '0;
        status_r <= STATUS_ORDER;
      end else if (nidx == '0) begin
        point_r  <= '0;
        index_r  <= '0;
        status_r <= STATUS_RANGE;
      end else if (tz_beyond) begin
        point_r  <= '0;
        index_r  <= nidx;
        status_r <= STATUS_RANGE;
      end else begin
        point_r  <= cur_point_r ^ rd_data;
        index_r  <= nidx;
        status_r <= STATUS_OK;
      end
    end
  end

  assign sts.scan_last = (bit_r == LAST_BIT);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_point_bits  = VALUE_W'(point_r);
  assign out_point_index = index_r;
  assign out_status      = status_r;

  // checks
  `ASSERT_NEXT(a_scan_counts, clk, rst_n, cmd.scan_step && bit_r != LAST_BIT,
               bit_r == $past(bit_r) + 5'd1)
  `ASSERT_NEXT(a_good_start_starts, clk, rst_n, cmd.finish_start && !err_r,
               started_r && cur_index_r == $past(sidx_r))
  `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_r && out_stall,
               out_valid_r && point_r == $past(point_r))

endmodule

`default_nettype wire

// File: rtl/core/gray_code_digital_net_generator.sv
// top level of the base-2 gray code digital net point generator
// depends on gcdn_pkg, gcdn_ctrl, gcdn_dp (and through it gcdn_ram)
//
//  channel | direction | handshake        | payload
//  in_     | input     | valid / stall    | operation, column_index, column_value, start_index
//  out_    | output    | valid / stall    | point_bits, point_index, status
//  cfg_    | input     | valid / ready    | data (columns_in_use)
//
// a load gives no result; a next reads one column from the store and xors it into the
// result register. a start scans the store one gray bit a cycle over 32 bits.
// reset is synchronous, active low; it needs no clearing pass, the store is not cleared.
// a held result stalls only the finishing cycle of the following item; a new item is
// still taken while a result waits.
`default_nettype none

module gray_code_digital_net_generator #(
  parameter int MAX_COLUMNS = gcdn_pkg::GCDN_MAX_COLUMNS,
  parameter int PRECISION   = gcdn_pkg::GCDN_PRECISION
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gcdn_pkg::OP_W-1:0]     in_operation,
  input  wire logic [gcdn_pkg::COL_W-1:0]    in_column_index,
  input  wire logic [gcdn_pkg::VALUE_W-1:0]  in_column_value,
  input  wire logic [gcdn_pkg::INDEX_W-1:0]  in_start_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gcdn_pkg::VALUE_W-1:0]       out_point_bits,
  output logic [gcdn_pkg::INDEX_W-1:0]       out_point_index,
  output logic [gcdn_pkg::STATUS_W-1:0]      out_status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [gcdn_pkg::CFG_W-1:0]    cfg_data
);
  import gcdn_pkg::*;

  gcdn_cmd_t cmd;
  gcdn_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  gcdn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  gcdn_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .PRECISION   (PRECISION)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_column_index (in_column_index),
    .in_column_value (in_column_value),
    .in_start_index  (in_start_index),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_bits  (out_point_bits),
    .out_point_index (out_point_index),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

// File: dv/gray_code_digital_net_generator_test.sv
// self-checking testbench of the gray code digital net point generator
// depends on gcdn_pkg and gray_code_digital_net_generator; drives loads, starts and nexts
// with random pacing and stalls, and checks each point against a predictor of its own
`default_nettype none

module gray_code_digital_net_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gcdn_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int NET_COLUMNS  = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET  = 650;

  localparam logic [VALUE_W-1:0] ONES64 = '1;
  localparam logic [VALUE_W-1:0] MSB64  = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] MIX64  = 64'h0123_4567_89ab_cdef;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] sidx;
  } net_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  bits;
    logic [INDEX_W-1:0]  pidx;
    logic [STATUS_W-1:0] status;
  } net_point_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [OP_W-1:0]     op;
    logic [COL_W-1:0]    col;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  sidx;
    logic                typed;
    logic [VALUE_W-1:0]  bits;
    logic [INDEX_W-1:0]  pidx;
    logic [STATUS_W-1:0] status;
  } stim_row_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_BURSTS} stall_mode_t;

  // directed rows; config rows carry the register value in the value field
  localparam stim_row_t DIRECTED_ROWS [28] = '{
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd0, STATUS_ORDER},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_LOAD,  5'd0,  ONES64, 32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_LOAD,  5'd1,  64'd0,  32'hffff_ffff, 1'b0, 64'd0, 32'd0, STATUS_OK},
    '{ROW_ITEM, OP_LOAD,  5'd31, MSB64,  32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd31, ONES64, 32'd1,        1'b1, ONES64, 32'd1, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, ONES64, 32'd2, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd3, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'hffff_ffff, 1'b1, MSB64,
      32'hffff_ffff, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd0, STATUS_RANGE},
    '{ROW_ITEM, OP_NONE,  5'd31, ONES64, 32'hffff_ffff, 1'b0, 64'd0, 32'd0, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'h8000_0000, 1'b0, 64'd0, 32'd0, STATUS_OK},
    '{ROW_ITEM, OP_LOAD,  5'd30, MIX64,  32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'h7fff_ffff, 1'b0, 64'd0, 32'd0, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_CFG,  OP_LOAD,  5'd0,  64'd1,  32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'd2,        1'b1, 64'd0,  32'd2, STATUS_RANGE},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd0, STATUS_ORDER},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'd1,        1'b1, ONES64, 32'd1, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd2, STATUS_RANGE},
    '{ROW_CFG,  OP_LOAD,  5'd0,  64'd0,  32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b1, 64'd0,  32'd1, STATUS_RANGE},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'd1,        1'b1, 64'd0,  32'd1, STATUS_RANGE},
    '{ROW_CFG,  OP_LOAD,  5'd0,  64'd63, 32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_ITEM, OP_START, 5'd0,  64'd0,  32'hdead_beef, 1'b0, 64'd0, 32'd0, STATUS_OK},
    '{ROW_ITEM, OP_NEXT,  5'd0,  64'd0,  32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK},
    '{ROW_CFG,  OP_LOAD,  5'd0,  64'd32, 32'd0,        1'b0, 64'd0,  32'd0, STATUS_OK}
  };

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation    = '0;
  logic [COL_W-1:0]    in_column_index = '0;
  logic [VALUE_W-1:0]  in_column_value = '0;
  logic [INDEX_W-1:0]  in_start_index  = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [VALUE_W-1:0]  out_point_bits;
  logic [INDEX_W-1:0]  out_point_index;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data        = '0;

  // predictor state
  logic [VALUE_W-1:0] column_store [NET_COLUMNS];
  logic [VALUE_W-1:0] walk_point;
  logic [INDEX_W-1:0] walk_index;
  logic               walk_running;
  logic [CFG_W-1:0]   columns_in_use;

  net_point_t pending_points [$];
  int error_count = 0;
  int item_count  = 0;
  int burst_left  = 0;

  gray_code_digital_net_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_column_index (in_column_index),
    .in_column_value (in_column_value),
    .in_start_index  (in_start_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_bits  (out_point_bits),
    .out_point_index (out_point_index),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int trailing_zero_count(input logic [INDEX_W-1:0] v);
    int n;
    n = 0;
    while (n < INDEX_W && !v[n]) n++;
    return n;
  endfunction

  // advance the predictor by one item; returns 1 when the item gives a point
  function automatic bit next_net_point(input net_item_t it, output net_point_t pt);
    int                 col_limit;
    int                 tz;
    logic [INDEX_W-1:0] gray;
    logic [INDEX_W-1:0] nidx;
    logic [VALUE_W-1:0] acc;
    col_limit = (columns_in_use < NET_COLUMNS) ? int'(columns_in_use) : NET_COLUMNS;
    pt = '0;
    case (it.op)
      OP_LOAD: begin
        column_store[it.col] = it.value;
        return 1'b0;
      end
      OP_START: begin
        gray = it.sidx ^ (it.sidx >> 1);
        acc  = '0;
        for (int b = 0; b < INDEX_W; b++) begin
          if (gray[b]) begin
            // gray bit selects a column out of use
            if (b >= col_limit) begin
              walk_running = 1'b0;
              pt = '{bits: '0, pidx: it.sidx, status: STATUS_RANGE};
              return 1'b1;
            end
            acc ^= column_store[COL_W'(b)];
          end
        end
        walk_point   = acc;
        walk_index   = it.sidx;
        walk_running = 1'b1;
        pt = '{bits: walk_point, pidx: walk_index, status: STATUS_OK};
        return 1'b1;
      end
      OP_NEXT: begin
        if (!walk_running) begin
          pt = '{bits: '0, pidx: '0, status: STATUS_ORDER};
          return 1'b1;
        end
        nidx = walk_index + 32'd1;
        // index wrap
        if (nidx == '0) begin
          pt = '{bits: '0, pidx: '0, status: STATUS_RANGE};
          return 1'b1;
        end
        tz = trailing_zero_count(nidx);
        if (tz >= col_limit) begin
          pt = '{bits: '0, pidx: nidx, status: STATUS_RANGE};
          return 1'b1;
        end
        walk_point ^= column_store[COL_W'(tz)];
        walk_index  = nidx;
        pt = '{bits: walk_point, pidx: walk_index, status: STATUS_OK};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // one input transfer with burst pacing; typed points replace the predicted one
  task automatic transfer_item(input net_item_t it, input logic typed,
                               input net_point_t typed_pt);
    net_point_t pt;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_operation    <= it.op;
    in_column_index <= it.col;
    in_column_value <= it.value;
    in_start_index  <= it.sidx;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (next_net_point(it, pt)) pending_points.push_back(typed ? typed_pt : pt);
    if (it.op != OP_NONE) item_count++;
  endtask

  // hold the sender until every point is back and the block has gone quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_columns_in_use(input logic [CFG_W-1:0] v);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    columns_in_use = v;
  endtask

  function automatic net_item_t random_item(input logic [OP_W-1:0] op);
    net_item_t it;
    it.op    = op;
    it.col   = COL_W'($urandom);
    it.value = {$urandom, $urandom};
    it.sidx  = $urandom;
    return it;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_start_index();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2, 3:    return 32'hffff_ffff - $urandom_range(0, 40);
      4:       return (32'd1 << $urandom_range(1, 31)) - $urandom_range(0, 6);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // result check and receiver stall pattern
  always @(posedge clk) begin : point_check
    net_point_t         want;
    static stall_mode_t stall_mode  = STALL_NONE;
    static int          mode_left   = 0;
    static int          run_left    = 0;
    static logic        stall_level = 1'b0;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point", out_point_bits, '0);
      end else begin
        want = pending_points.pop_front();
        if (out_point_bits !== want.bits)
          report_mismatch("point_bits", out_point_bits, want.bits);
        if (out_point_index !== want.pidx)
          report_mismatch("point_index", 64'(out_point_index), 64'(want.pidx));
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
      end
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 150);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default: begin
        if (run_left == 0) begin
          stall_level = ~stall_level;
          run_left = stall_level ? $urandom_range(1, 25) : $urandom_range(1, 6);
        end
        run_left--;
        out_stall <= stall_level;
      end
    endcase
  end

  initial begin : stimulus
    net_item_t        it;
    net_point_t       typed_pt;
    stim_row_t        row;
    int               roll;
    int               next_cfg_at;
    logic [CFG_W-1:0] cfg_pick;
    walk_point     = '0;
    walk_index     = '0;
    walk_running   = 1'b0;
    columns_in_use = CFG_RESET;

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // write every column first so no start or next reads an empty one
    for (int c = 0; c < NET_COLUMNS; c++) begin
      it     = random_item(OP_LOAD);
      it.col = COL_W'(c);
      transfer_item(it, 1'b0, '0);
    end

    // directed rows
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_CFG) begin
        write_columns_in_use(row.value[CFG_W-1:0]);
      end else begin
        it       = '{row.op, row.col, row.value, row.sidx};
        typed_pt = '{row.bits, row.pidx, row.status};
        transfer_item(it, row.typed, typed_pt);
      end
    end

    // random walks, loads, noise and register changes
    next_cfg_at = item_count + $urandom_range(60, 140);
    while (item_count < ITEM_TARGET) begin
      if (item_count >= next_cfg_at) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)      cfg_pick = CFG_W'($urandom_range(32, 63));
        else if (roll < 85) cfg_pick = CFG_W'($urandom_range(4, 31));
        else                cfg_pick = CFG_W'($urandom_range(0, 3));
        write_columns_in_use(cfg_pick);
        next_cfg_at = item_count + $urandom_range(60, 140);
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // start then a run of nexts
        it      = random_item(OP_START);
        it.sidx = pick_start_index();
        transfer_item(it, 1'b0, '0);
        repeat ($urandom_range(0, 40)) transfer_item(random_item(OP_NEXT), 1'b0, '0);
      end else if (roll < 75) begin
        repeat ($urandom_range(1, 4)) transfer_item(random_item(OP_LOAD), 1'b0, '0);
      end else if (roll < 88) begin
        repeat ($urandom_range(1, 3))
          transfer_item(random_item(OP_W'($urandom_range(0, 3))), 1'b0, '0);
      end else if (roll < 97) begin
        // stray nexts on whatever walk is left
        repeat ($urandom_range(1, 5)) transfer_item(random_item(OP_NEXT), 1'b0, '0);
      end else begin
        settle_block();
      end
    end

    // drain and finish
    settle_block();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
